[hw/rtl/tone_sequence_player_assert.svh]
// assertion helpers for the tone sequence player
`ifndef TONE_SEQUENCE_PLAYER_ASSERT_SVH
`define TONE_SEQUENCE_PLAYER_ASSERT_SVH

// condition that must hold at every edge out of reset
`define TSP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define TSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int SOUND_SLOTS = 16;
  localparam int SLOT_W      = $clog2(SOUND_SLOTS);
  localparam int STEP_W      = SLOT_W + 1;
  localparam int WALK_LIMIT  = 4 * SOUND_SLOTS + 4;
  localparam int WALK_W      = $clog2(WALK_LIMIT + 1);

  localparam int OP_W     = 3;
  localparam int IDX_W    = 4;
  localparam int CMD_W    = 2;
  localparam int DUR_W    = 8;
  localparam int CNT_W    = 3;
  localparam int TGT_W    = 4;
  localparam int TPU_W    = 16;
  localparam int PROD_W   = DUR_W + TPU_W;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [STEP_W-1:0] step_idx_t;
  typedef logic [WALK_W-1:0] walk_cnt_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(SOUND_SLOTS - 1);
  localparam step_idx_t STEP_END  = step_idx_t'(SOUND_SLOTS);
  localparam walk_cnt_t WALK_MAX  = walk_cnt_t'(WALK_LIMIT);

  localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(1600);

  localparam logic [OP_W-1:0] OP_LOAD        = 3'd0;
  localparam logic [OP_W-1:0] OP_START_ONCE  = 3'd1;
  localparam logic [OP_W-1:0] OP_START_ALARM = 3'd2;
  localparam logic [OP_W-1:0] OP_OFF         = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK        = 3'd4;

  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPEAT = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [DUR_W-1:0] dur;
    logic [CNT_W-1:0] count;
    logic [TGT_W-1:0] target;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/tone_sequence_player.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "tone_sequence_player_assert.svh"

// Buzzer sequence player. Every input item gives exactly one result item: the buzzer
// level, the playing flag and the alarm flag as they stand after the item. Load, off,
// unused codes and ticks that do not end a countdown complete in the idle state and their
// result appears in the cycle after they are taken. A start copies the source store into
// the working store, one source read and one working write per slot copied (the source
// store has a single registered read port), and then walks the working store, visiting
// each entry through a check state and an execute state, with one read of the working
// store and the single duration multiplier; a tick that ends a countdown walks the same
// way. An alarm that reaches its stop entry copies again within the same item. The worst
// item, an alarm that bounces between a repeat and a stop over a full store until the
// walk limit of 4 * SOUND_SLOTS + 4 entries, recopies the store each round. A new item
// is taken once the previous result is gone or being taken in the same cycle. The
// configuration write port is always ready.
module tone_sequence_player (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tsp_pkg::TPU_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tsp_pkg::OP_W-1:0]    in_operation,
  input  wire logic [tsp_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic [tsp_pkg::CMD_W-1:0]   in_entry_command,
  input  wire logic [tsp_pkg::DUR_W-1:0]   in_entry_time,
  input  wire logic [tsp_pkg::CNT_W-1:0]   in_entry_count,
  input  wire logic [tsp_pkg::TGT_W-1:0]   in_entry_target,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_buzzer_on,
  output logic                             out_playing,
  output logic                             out_alarm_mode
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CP_RD   = 3'd1;
  localparam logic [2:0] S_CP_WR   = 3'd2;
  localparam logic [2:0] S_ADV_CHK = 3'd3;
  localparam logic [2:0] S_ADV_EX  = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  tsp_pkg::slot_idx_t            cp_idx_r, cp_idx_nxt;
  tsp_pkg::walk_cnt_t            walk_r, walk_nxt;
  tsp_pkg::step_idx_t            step_r, step_nxt;
  logic                          alarm_r, alarm_nxt;
  logic                          drive_r, drive_nxt;
  logic                          running_r, running_nxt;
  logic [tsp_pkg::TPU_W-1:0]     ticks_r, ticks_nxt;
  logic [tsp_pkg::TPU_W-1:0]     tpu_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          src0_loaded_r, src0_loaded_nxt;

  tsp_pkg::entry_t               src_mem [tsp_pkg::SOUND_SLOTS];
  tsp_pkg::entry_t               wrk_mem [tsp_pkg::SOUND_SLOTS];
  tsp_pkg::entry_t               src_rd_r;
  tsp_pkg::entry_t               wrk_rd_r;

  logic                          in_fire;
  logic                          src_we;
  tsp_pkg::entry_t               src_wdata;
  tsp_pkg::slot_idx_t            src_waddr;
  logic                          wrk_we;
  tsp_pkg::entry_t               wrk_wdata;
  tsp_pkg::slot_idx_t            wrk_waddr;
  logic                          src_is_stop;
  logic [tsp_pkg::TPU_W-1:0]     prod;
  logic [tsp_pkg::TPU_W-1:0]     tick_dec;

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_buzzer_on  = drive_r;
  assign out_playing    = running_r;
  assign out_alarm_mode = alarm_r;

  assign src_waddr = tsp_pkg::slot_idx_t'(in_entry_index);
  assign src_wdata = '{cmd: in_entry_command, dur: in_entry_time,
                       count: in_entry_count, target: in_entry_target};

  // slot 0 reads as stop until it has been loaded
  assign src_is_stop = (src_rd_r.cmd == tsp_pkg::CMD_STOP) ||
                       ((cp_idx_r == '0) && !src0_loaded_r);

  // countdown length kept to 16 bits
  assign prod     = tsp_pkg::TPU_W'(wrk_rd_r.dur) * tpu_r;
  assign tick_dec = (ticks_r != '0) ? ticks_r - 1'b1 : ticks_r;

  always_comb begin
    state_nxt       = state_r;
    cp_idx_nxt      = cp_idx_r;
    walk_nxt        = walk_r;
    step_nxt        = step_r;
    alarm_nxt       = alarm_r;
    drive_nxt       = drive_r;
    running_nxt     = running_r;
    ticks_nxt       = ticks_r;
    src0_loaded_nxt = src0_loaded_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    src_we          = 1'b0;
    wrk_we          = 1'b0;
    wrk_wdata       = '0;
    wrk_waddr       = cp_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_operation)
            tsp_pkg::OP_LOAD: begin
              if (32'(in_entry_index) < tsp_pkg::SOUND_SLOTS) begin
                src_we = 1'b1;
                if (src_waddr == '0) begin
                  src0_loaded_nxt = 1'b1;
                end
              end
              out_valid_nxt = 1'b1;
            end
            tsp_pkg::OP_START_ONCE, tsp_pkg::OP_START_ALARM: begin
              running_nxt = 1'b0;
              step_nxt    = '0;
              drive_nxt   = 1'b0;
              if (in_operation == tsp_pkg::OP_START_ALARM) begin
                alarm_nxt = 1'b1;
              end
              cp_idx_nxt = '0;
              walk_nxt   = '0;
              state_nxt  = S_CP_RD;
            end
            tsp_pkg::OP_OFF: begin
              alarm_nxt     = 1'b0;
              running_nxt   = 1'b0;
              step_nxt      = '0;
              drive_nxt     = 1'b0;
              out_valid_nxt = 1'b1;
            end
            tsp_pkg::OP_TICK: begin
              if (running_r) begin
                ticks_nxt = tick_dec;
                if (tick_dec == '0) begin
                  walk_nxt  = '0;
                  state_nxt = S_ADV_CHK;
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CP_RD: begin
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        wrk_we = 1'b1;
        if (!src_is_stop && (cp_idx_r != tsp_pkg::LAST_SLOT)) begin
          wrk_wdata  = src_rd_r;
          cp_idx_nxt = cp_idx_r + 1'b1;
          state_nxt  = S_CP_RD;
        end else begin
          // terminating stop entry
          wrk_wdata = '0;
          state_nxt = S_ADV_CHK;
        end
      end
      S_ADV_CHK: begin
        if (walk_r >= tsp_pkg::WALK_MAX) begin
          alarm_nxt     = 1'b0;
          running_nxt   = 1'b0;
          step_nxt      = '0;
          drive_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (step_r >= tsp_pkg::STEP_END) begin
          running_nxt   = 1'b0;
          step_nxt      = '0;
          drive_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          walk_nxt  = walk_r + 1'b1;
          state_nxt = S_ADV_EX;
        end
      end
      S_ADV_EX: begin
        unique case (wrk_rd_r.cmd)
          tsp_pkg::CMD_PLAY, tsp_pkg::CMD_PAUSE: begin
            drive_nxt     = (wrk_rd_r.cmd == tsp_pkg::CMD_PLAY);
            ticks_nxt     = (prod == '0) ? tsp_pkg::TPU_W'(1) : prod;
            running_nxt   = 1'b1;
            step_nxt      = step_r + 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          tsp_pkg::CMD_REPEAT: begin
            if (wrk_rd_r.count == '0) begin
              step_nxt = tsp_pkg::step_idx_t'(wrk_rd_r.target);
            end else if (wrk_rd_r.count == tsp_pkg::CNT_W'(1)) begin
              step_nxt = step_r + 1'b1;
            end else begin
              wrk_we          = 1'b1;
              wrk_waddr       = step_r[tsp_pkg::SLOT_W-1:0];
              wrk_wdata       = wrk_rd_r;
              wrk_wdata.count = wrk_rd_r.count - 1'b1;
              step_nxt        = tsp_pkg::step_idx_t'(wrk_rd_r.target);
            end
            state_nxt = S_ADV_CHK;
          end
          tsp_pkg::CMD_STOP: begin
            running_nxt = 1'b0;
            step_nxt    = '0;
            drive_nxt   = 1'b0;
            if (alarm_r) begin
              // alarm: reload from the source store and go round again
              cp_idx_nxt = '0;
              state_nxt  = S_CP_RD;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cp_idx_r      <= '0;
      walk_r        <= '0;
      step_r        <= '0;
      alarm_r       <= 1'b0;
      drive_r       <= 1'b0;
      running_r     <= 1'b0;
      ticks_r       <= '0;
      tpu_r         <= tsp_pkg::TPU_RESET;
      out_valid_r   <= 1'b0;
      src0_loaded_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cp_idx_r      <= cp_idx_nxt;
      walk_r        <= walk_nxt;
      step_r        <= step_nxt;
      alarm_r       <= alarm_nxt;
      drive_r       <= drive_nxt;
      running_r     <= running_nxt;
      ticks_r       <= ticks_nxt;
      out_valid_r   <= out_valid_nxt;
      src0_loaded_r <= src0_loaded_nxt;
      if (cfg_valid && cfg_ready) begin
        tpu_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    src_rd_r <= src_mem[cp_idx_r];
  end

  always_ff @(posedge clk) begin
    if (wrk_we) begin
      wrk_mem[wrk_waddr] <= wrk_wdata;
    end
    wrk_rd_r <= wrk_mem[step_r[tsp_pkg::SLOT_W-1:0]];
  end

  `TSP_ASSERT_ALWAYS(a_busy_no_result, (state_r == S_IDLE) || !out_valid_r,
                     "sequencer busy while a result is still pending")
  `TSP_ASSERT_ALWAYS(a_idle_running_timer, (state_r != S_IDLE) || !running_r || (ticks_r != '0),
                     "running with an empty countdown")
  `TSP_ASSERT_ALWAYS(a_walk_bound, walk_r <= tsp_pkg::WALK_MAX,
                     "walk counter past its limit")
  `TSP_ASSERT_ALWAYS(a_step_bound, step_r <= tsp_pkg::STEP_END,
                     "step index past the store")
  `TSP_ASSERT_NEXT(a_load_result, in_fire && (in_operation == tsp_pkg::OP_LOAD),
                   out_valid_r && (state_r == S_IDLE), "load item gave no result")

endmodule

`default_nettype wire
